// ----- rtl/core/rau_pkg.sv -----
// Package for the rational arithmetic unit: item types, codes, micro-op table
// and divider request/response types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] a_numerator;
    logic signed [31:0] a_denominator;
    logic signed [31:0] b_numerator;
    logic signed [31:0] b_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_numerator;
    logic signed [31:0] res_denominator;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DZ = 2'd1;
  localparam logic [1:0] ST_OV = 2'd2;

  localparam int unsigned NumSteps = 8;
  localparam int unsigned StepW    = 3;

  typedef enum logic [1:0] {K_GCD, K_DIV, K_MUL, K_ADD} kind_e;

  typedef enum logic [3:0] {
    SRC_AN, SRC_AD, SRC_BN, SRC_BD, SRC_T0, SRC_T1, SRC_T2, SRC_G1, SRC_G2
  } src_e;

  typedef enum logic [2:0] {DST_T0, DST_T1, DST_T2, DST_G1, DST_G2} dst_e;

  typedef struct packed {
    kind_e kind;
    src_e  src_a;
    src_e  src_b;
    dst_e  dst;
  } uop_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

  // Fixed programs: add/sub path and multiply path (divide has b swapped on load).
  function automatic uop_t decode_uop(input logic mul_path, input logic [StepW-1:0] step);
    uop_t u;
    u = '{kind: K_ADD, src_a: SRC_T1, src_b: SRC_T2, dst: DST_T1};
    if (!mul_path) begin
      unique case (step)
        3'd0: u = '{kind: K_GCD, src_a: SRC_AD, src_b: SRC_BD, dst: DST_G1};
        3'd1: u = '{kind: K_MUL, src_a: SRC_AD, src_b: SRC_BD, dst: DST_T0};
        3'd2: u = '{kind: K_DIV, src_a: SRC_T0, src_b: SRC_G1, dst: DST_T0};
        3'd3: u = '{kind: K_DIV, src_a: SRC_T0, src_b: SRC_AD, dst: DST_T1};
        3'd4: u = '{kind: K_MUL, src_a: SRC_T1, src_b: SRC_AN, dst: DST_T1};
        3'd5: u = '{kind: K_DIV, src_a: SRC_T0, src_b: SRC_BD, dst: DST_T2};
        3'd6: u = '{kind: K_MUL, src_a: SRC_T2, src_b: SRC_BN, dst: DST_T2};
        default: u = '{kind: K_ADD, src_a: SRC_T1, src_b: SRC_T2, dst: DST_T1};
      endcase
    end else begin
      unique case (step)
        3'd0: u = '{kind: K_GCD, src_a: SRC_AN, src_b: SRC_BD, dst: DST_G1};
        3'd1: u = '{kind: K_GCD, src_a: SRC_BN, src_b: SRC_AD, dst: DST_G2};
        3'd2: u = '{kind: K_DIV, src_a: SRC_AN, src_b: SRC_G1, dst: DST_T1};
        3'd3: u = '{kind: K_DIV, src_a: SRC_BN, src_b: SRC_G2, dst: DST_T2};
        3'd4: u = '{kind: K_MUL, src_a: SRC_T1, src_b: SRC_T2, dst: DST_T0};
        3'd5: u = '{kind: K_DIV, src_a: SRC_AD, src_b: SRC_G2, dst: DST_T1};
        3'd6: u = '{kind: K_DIV, src_a: SRC_BD, src_b: SRC_G1, dst: DST_T2};
        default: u = '{kind: K_MUL, src_a: SRC_T1, src_b: SRC_T2, dst: DST_T1};
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rau_div.sv -----
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// Uses rau_pkg for the request/response types.
`timescale 1ns / 1ps
`default_nettype none

module rau_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t     rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] shifted;
  logic [33:0] diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/rational_arith_unit.sv -----
// Rational arithmetic unit top level: micro-op sequencer around a shared
// divider and a single 32x32 multiplier. Depends on rau_pkg and rau_div.
//
// Usage: an item (opcode plus two fractions) is transferred on the input
// channel when in_valid_i is high and in_stall_o is low. One result fraction
// with a status leaves on the output channel when out_valid_o is high and
// out_stall_i is low. The result sits in an output register; it holds while
// out_stall_i is high.
// Each item runs a fixed program of eight micro-ops. A multiply or add
// writes back from the issue state; a signed division runs on the shared
// restoring divider on magnitudes; a gcd runs one division per Euclid step
// (up to about 46 steps), also on that divider. Add/sub: one gcd plus three
// divisions; multiply/divide: two gcds plus four divisions. An item flagged
// as a zero divisor on load skips the program and goes straight to write-back.
// in_stall_o is high from transfer until the result is handed to the output
// register, so one item is in flight at a time. If the output register is
// still occupied, the finished item waits. Reset clears the sequencer and
// the output valid; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rau_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rau_pkg::out_item_t     out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_DIVW  = 6'b000100,
    S_GCDL  = 6'b001000,
    S_GCDW  = 6'b010000,
    S_WB    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [rau_pkg::StepW-1:0] stp_q, stp_d;
  logic        mul_q, sub_q, zd_q, ov_q, neg_q, neg_d;
  logic [31:0] an_q, ad_q, bn_q, bd_q, t0_q, t1_q, t2_q, g1_q, g2_q;
  logic [31:0] gp_q, gp_d, gq_q, gq_d;
  logic        out_vld_q;
  rau_pkg::out_item_t out_q;

  rau_pkg::uop_t     uop;
  rau_pkg::div_req_t div_req;
  rau_pkg::div_rsp_t div_rsp;

  logic        ld_in, out_ld, wr_en, ov_set, zero_in, in_mul;
  logic [31:0] wr_val, opa, opb, mag_a, mag_b, mag_bs, qsig;
  logic        b_uns;
  logic signed [63:0] mul_full;
  logic [32:0] sum;
  logic [31:0] ld_bn, ld_bd;

  function automatic logic [31:0] pick(input rau_pkg::src_e s,
                                       input logic [31:0] an, ad, bn, bd,
                                       input logic [31:0] t0, t1, t2, g1, g2);
    logic [31:0] v;
    unique case (s)
      rau_pkg::SRC_AN: v = an;
      rau_pkg::SRC_AD: v = ad;
      rau_pkg::SRC_BN: v = bn;
      rau_pkg::SRC_BD: v = bd;
      rau_pkg::SRC_T0: v = t0;
      rau_pkg::SRC_T1: v = t1;
      rau_pkg::SRC_T2: v = t2;
      rau_pkg::SRC_G1: v = g1;
      rau_pkg::SRC_G2: v = g2;
      default:         v = '0;
    endcase
    return v;
  endfunction

  rau_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign uop = rau_pkg::decode_uop(mul_q, stp_q);
  assign opa = pick(uop.src_a, an_q, ad_q, bn_q, bd_q, t0_q, t1_q, t2_q, g1_q, g2_q);
  assign opb = pick(uop.src_b, an_q, ad_q, bn_q, bd_q, t0_q, t1_q, t2_q, g1_q, g2_q);
  assign b_uns  = (uop.src_b == rau_pkg::SRC_G1) || (uop.src_b == rau_pkg::SRC_G2);
  assign mag_a  = opa[31] ? (32'd0 - opa) : opa;
  assign mag_bs = opb[31] ? (32'd0 - opb) : opb;
  assign mag_b  = b_uns ? opb : mag_bs;

  assign mul_full = $signed(opa) * $signed(opb);
  assign sum = sub_q ? ({t1_q[31], t1_q} - {t2_q[31], t2_q})
                     : ({t1_q[31], t1_q} + {t2_q[31], t2_q});
  assign qsig = neg_q ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;

  // Divide swaps b on load so it runs the multiply program.
  assign in_mul = in_data_i.opcode[1];
  assign ld_bn  = (in_data_i.opcode == rau_pkg::OP_DIV) ? in_data_i.b_denominator
                                                         : in_data_i.b_numerator;
  assign ld_bd  = (in_data_i.opcode == rau_pkg::OP_DIV) ? in_data_i.b_numerator
                                                         : in_data_i.b_denominator;
  assign zero_in = in_mul
    ? ((in_data_i.a_numerator == 32'sd0 && ld_bd == 32'd0) ||
       (ld_bn == 32'd0 && in_data_i.a_denominator == 32'sd0))
    : (in_data_i.a_denominator == 32'sd0 || in_data_i.b_denominator == 32'sd0);

  always_comb begin
    state_d = state_q;
    stp_d   = stp_q;
    neg_d   = neg_q;
    gp_d    = gp_q;
    gq_d    = gq_q;
    wr_en   = 1'b0;
    wr_val  = '0;
    ov_set  = 1'b0;
    ld_in   = 1'b0;
    out_ld  = 1'b0;
    div_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ld_in   = 1'b1;
          stp_d   = '0;
          state_d = zero_in ? S_WB : S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (uop.kind)
          rau_pkg::K_MUL: begin
            wr_en  = 1'b1;
            wr_val = mul_full[31:0];
            ov_set = !((&mul_full[63:31]) || !(|mul_full[63:31]));
          end
          rau_pkg::K_ADD: begin
            wr_en  = 1'b1;
            wr_val = sum[31:0];
            ov_set = sum[32] ^ sum[31];
          end
          rau_pkg::K_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = mag_a;
            div_req.divisor  = mag_b;
            neg_d   = opa[31] ^ (!b_uns && opb[31]);
            state_d = S_DIVW;
          end
          default: begin
            gp_d    = mag_a;
            gq_d    = mag_bs;
            state_d = S_GCDL;
          end
        endcase
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          wr_en  = 1'b1;
          wr_val = qsig;
          ov_set = !neg_q && div_rsp.quotient[31];
        end
      end
      S_GCDL: begin
        if (gq_q == 32'd0) begin
          wr_en  = 1'b1;
          wr_val = gp_q;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = gp_q;
          div_req.divisor  = gq_q;
          state_d = S_GCDW;
        end
      end
      S_GCDW: begin
        if (div_rsp.done) begin
          gp_d    = gq_q;
          gq_d    = div_rsp.remainder;
          state_d = S_GCDL;
        end
      end
      S_WB: begin
        if (!out_vld_q || !out_stall_i) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a micro-op finished: step on or hand over the result
    if (wr_en) begin
      if (stp_q == rau_pkg::StepW'(rau_pkg::NumSteps - 1)) begin
        state_d = S_WB;
      end else begin
        stp_d   = stp_q + 1'b1;
        state_d = S_ISSUE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stp_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stp_q   <= stp_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    gp_q  <= gp_d;
    gq_q  <= gq_d;
    if (ld_in) begin
      an_q  <= in_data_i.a_numerator;
      ad_q  <= in_data_i.a_denominator;
      bn_q  <= ld_bn;
      bd_q  <= ld_bd;
      mul_q <= in_mul;
      sub_q <= (in_data_i.opcode == rau_pkg::OP_SUB);
      zd_q  <= zero_in;
      ov_q  <= 1'b0;
    end else if (ov_set) begin
      ov_q <= 1'b1;
    end
    if (wr_en) begin
      unique case (uop.dst)
        rau_pkg::DST_T0: t0_q <= wr_val;
        rau_pkg::DST_T1: t1_q <= wr_val;
        rau_pkg::DST_T2: t2_q <= wr_val;
        rau_pkg::DST_G1: g1_q <= wr_val;
        rau_pkg::DST_G2: g2_q <= wr_val;
        default: ;
      endcase
    end
    if (out_ld) begin
      if (zd_q) begin
        out_q.res_numerator   <= '0;
        out_q.res_denominator <= '0;
        out_q.status          <= rau_pkg::ST_DZ;
      end else begin
        out_q.res_numerator   <= mul_q ? t0_q : t1_q;
        out_q.res_denominator <= mul_q ? t1_q : t0_q;
        out_q.status          <= ov_q ? rau_pkg::ST_OV : rau_pkg::ST_OK;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVW || state_q == S_GCDW))
    else $error("divider result with no waiting micro-op");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == rau_pkg::ST_DZ) |->
      (out_data_o.res_numerator == 32'sd0 && out_data_o.res_denominator == 32'sd0))
    else $error("zero-divisor result carries a nonzero fraction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("sequencer idle after an input transfer");
`endif

endmodule

`default_nettype wire
